/* src/buffer_cache_getblk_brelse_core_defines.svh */
// Assertion macros for the buffer cache core
`ifndef BUFFER_CACHE_GETBLK_BRELSE_CORE_DEFINES_SVH
`define BUFFER_CACHE_GETBLK_BRELSE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/bc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bc_pkg
// Types and codes shared by the buffer cache core.
// ---------------------------------------------------------------------------
package bc_pkg;
  localparam int NUM_BUFFERS_DEF = 8;
  localparam int BLOCK_BITS_DEF  = 16;

  typedef enum logic [1:0] {ST_FREE = 2'd0, ST_BUSY = 2'd1, ST_DELAYED = 2'd2} bstat_t;

  typedef enum logic [2:0] {
    OC_HIT = 3'd0, OC_MISS = 3'd1, OC_RETRY_BUSY = 3'd2, OC_RETRY_EMPTY = 3'd3,
    OC_RELEASED = 3'd4, OC_REL_ERROR = 3'd5, OC_WRITEBACK = 3'd6
  } outc_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_LINK, S_OUT
  } fsm_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [2:0]  index;
    logic [15:0] blk;
    logic        last;
  } res_t;
endpackage

/* src/bc_out_reg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bc_out_reg
// Result beat register between the sequencer and the master port.
// ---------------------------------------------------------------------------
module bc_out_reg import bc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  res_t        din,
  output logic        full,
  output logic        tvalid,
  input  logic        tready,
  output res_t        dout
);
  logic vld_r;
  res_t dat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (push) begin
      vld_r <= 1'b1;
    end else if (tready) begin
      vld_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (push) begin
      dat_r <= din;
    end
  end
  assign full   = vld_r && !tready;
  assign tvalid = vld_r;
  assign dout   = dat_r;
endmodule

/* src/buffer_cache_getblk_brelse_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buffer cache core: get/release on a pool of block buffers, one comparator.
// A request is scanned over every buffer, then decided; a grant or release adds a
// link step, a writeback an extra result beat, and output stalls hold the decide step.
// Requests are taken only in idle. Reset or a pool_size write re-initialises the pool.
// ---------------------------------------------------------------------------
`include "buffer_cache_getblk_brelse_core_defines.svh"
module buffer_cache_getblk_brelse_core import bc_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
  parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // disk_block[15:0], process_id[23:16]
  input  logic [1:0]  in_tuser,   // kind[0], release_status[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // outcome[2:0], buffer_index[5:3], result_block[21:6]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CW = $clog2(NUM_BUFFERS + 1);

  logic [BLOCK_BITS-1:0] tag_r [NUM_BUFFERS];
  logic [7:0]            own_r [NUM_BUFFERS];
  bstat_t                st_r  [NUM_BUFFERS];
  logic [IW-1:0]         nx_r  [NUM_BUFFERS];
  logic [IW-1:0]         pv_r  [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] vld_r, inl_r;
  logic [IW-1:0] head_r, tail_r;
  logic [CW-1:0] cnt_r, n_r;
  logic [3:0]    psz_r;

  fsm_t state_r, state_nxt;
  logic [IW-1:0] ptr_r;
  logic          hit_r;
  logic [IW-1:0] hidx_r;
  logic          kind_r, rel_r, wb_r;
  logic [BLOCK_BITS-1:0] blk_r;
  logic [7:0]    pid_r;
  logic [IW-1:0] e_r;
  res_t          res;
  logic          push, full, finish;
  res_t          od;

  logic [CW-1:0] nsz;
  always_comb begin
    if (psz_r == 4'd0) nsz = CW'(1);
    else if ({28'd0, psz_r} > 32'(NUM_BUFFERS)) nsz = CW'(NUM_BUFFERS);
    else nsz = CW'(psz_r);
  end

  wire last_ptr = ({{(32-IW){1'b0}}, ptr_r} == 32'(NUM_BUFFERS - 1));
  wire tag_eq   = vld_r[ptr_r] && (tag_r[ptr_r] == blk_r);

  assign cfg_ready = (state_r == S_IDLE) && !out_tvalid;
  assign in_tready = (state_r == S_IDLE) && !(cfg_valid && cfg_ready);

  // Result selection
  logic [IW-1:0] hd;
  always_comb begin
    hd = head_r;
    res = '0;
    finish = 1'b1;
    if (kind_r == 1'b0) begin
      if (hit_r) begin
        res.index = 3'(hidx_r);
        res.blk = 16'(tag_r[hidx_r]);
        res.outcome = (st_r[hidx_r] == ST_BUSY) ? OC_RETRY_BUSY : OC_HIT;
      end else if (cnt_r == '0) begin
        res.outcome = OC_RETRY_EMPTY;
        res.blk = 16'(blk_r);
      end else if (st_r[hd] == ST_DELAYED && !wb_r) begin
        res.outcome = OC_WRITEBACK;
        res.index = 3'(hd);
        res.blk = 16'(tag_r[hd]);
        finish = 1'b0;
      end else begin
        res.outcome = OC_MISS;
        res.index = 3'(hd);
        res.blk = 16'(blk_r);
      end
    end else begin
      if (!hit_r) begin
        res.outcome = OC_REL_ERROR;
        res.blk = 16'(blk_r);
      end else begin
        res.index = 3'(hidx_r);
        res.blk = 16'(tag_r[hidx_r]);
        res.outcome = (st_r[hidx_r] == ST_BUSY) ? OC_RELEASED : OC_REL_ERROR;
      end
    end
    res.last = finish;
  end

  assign push = (state_r == S_DECIDE) && !full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:   if (last_ptr) state_nxt = S_IDLE;
      S_IDLE: begin
        if (cfg_valid && cfg_ready) state_nxt = S_INIT;
        else if (in_tvalid) state_nxt = S_SCAN;
      end
      S_SCAN:   if (last_ptr) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (push) begin
          if (!finish) state_nxt = S_DECIDE;
          else if (res.outcome == OC_HIT || res.outcome == OC_MISS ||
                   res.outcome == OC_RELEASED) state_nxt = S_LINK;
          else state_nxt = S_IDLE;
        end
      end
      S_LINK:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ptr_r <= '0;
      psz_r <= 4'd8;
      n_r <= CW'(NUM_BUFFERS);
      vld_r <= '0;
      inl_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r <= '0;
      wb_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_INIT: begin
          if (ptr_r == '0) n_r <= nsz;
          tag_r[ptr_r] <= '0;
          own_r[ptr_r] <= '0;
          st_r[ptr_r] <= ST_FREE;
          vld_r[ptr_r] <= 1'b0;
          inl_r[ptr_r] <= (CW'(ptr_r) < nsz);
          nx_r[ptr_r] <= ((CW'(ptr_r) + CW'(1)) == nsz) ? '0 : ptr_r + 1'b1;
          pv_r[ptr_r] <= (ptr_r == '0) ? IW'(nsz - 1'b1) : ptr_r - 1'b1;
          head_r <= '0;
          tail_r <= IW'(nsz - 1'b1);
          cnt_r <= nsz;
          ptr_r <= last_ptr ? '0 : ptr_r + 1'b1;
        end
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            psz_r <= cfg_data;
          end else if (in_tvalid) begin
            kind_r <= in_tuser[0];
            rel_r <= in_tuser[1];
            blk_r <= BLOCK_BITS'(in_tdata[15:0]);
            pid_r <= in_tdata[23:16];
            hit_r <= 1'b0;
            wb_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (tag_eq && !hit_r) begin
            hit_r <= 1'b1;
            hidx_r <= ptr_r;
          end
          ptr_r <= last_ptr ? '0 : ptr_r + 1'b1;
        end
        S_DECIDE: begin
          if (push) begin
            if (!finish) begin
              st_r[hd] <= ST_FREE;
            end
            e_r <= hit_r ? hidx_r : hd;
            ptr_r <= '0;
            wb_r <= !finish;
          end
        end
        S_LINK: begin
          if (kind_r == 1'b0) begin
            st_r[e_r] <= ST_BUSY;
            own_r[e_r] <= pid_r;
            if (!hit_r) begin
              tag_r[e_r] <= blk_r;
              vld_r[e_r] <= 1'b1;
            end
            if (inl_r[e_r] && cnt_r != '0) begin
              inl_r[e_r] <= 1'b0;
              cnt_r <= cnt_r - 1'b1;
              if (cnt_r != CW'(1)) begin
                nx_r[pv_r[e_r]] <= nx_r[e_r];
                pv_r[nx_r[e_r]] <= pv_r[e_r];
                if (head_r == e_r) head_r <= nx_r[e_r];
                if (tail_r == e_r) tail_r <= pv_r[e_r];
              end
            end
          end else begin
            st_r[e_r] <= rel_r ? ST_DELAYED : ST_FREE;
            if (!inl_r[e_r]) begin
              inl_r[e_r] <= 1'b1;
              cnt_r <= cnt_r + 1'b1;
              tail_r <= e_r;
              if (cnt_r == '0) begin
                nx_r[e_r] <= e_r;
                pv_r[e_r] <= e_r;
                head_r <= e_r;
              end else begin
                pv_r[e_r] <= tail_r;
                nx_r[e_r] <= head_r;
                nx_r[tail_r] <= e_r;
                pv_r[head_r] <= e_r;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  bc_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .push(push), .din(res), .full(full),
    .tvalid(out_tvalid), .tready(out_tready), .dout(od)
  );

  assign out_tdata = {2'b00, od.blk, od.index, od.outcome};
  assign out_tlast = od.last;

  `BC_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= n_r)
  `BC_ASSERT_NXT(a_in_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `BC_ASSERT_IMP(a_push_room, clk, rst_n, push, !full)
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buffer cache core testbench
// Drives get and release requests through the input stream, keeps its own
// model of the buffer pool and free list, and checks every result beat in
// order. Pool size is rewritten between phases, the extremes included.
// ---------------------------------------------------------------------------
module tb;
  import bc_pkg::*;

  localparam int NBUF = 8;
  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        kind;
    logic [15:0] blk;
    logic [7:0]  pid;
    logic        rel;
  } req_t;

  typedef struct packed {
    outc_t       oc;
    logic [2:0]  idx;
    logic [15:0] blk;
    logic        last;
  } rsp_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_valid = 0;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic [3:0] cfg_data = '0;
  logic in_tready, out_tvalid, out_tlast, cfg_ready;
  logic [23:0] out_tdata;

  buffer_cache_getblk_brelse_core uut (.*);

  initial forever #5 clk = ~clk;

  // pool model
  logic [15:0] m_tag [NBUF];
  logic        m_val [NBUF];
  bstat_t      m_st  [NBUF];
  logic        m_inl [NBUF];
  int          m_nxt [NBUF];
  int          m_prv [NBUF];
  int          m_head, m_tail, m_cnt;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0, n_beats = 0, n_wb = 0, n_rel = 0, wdog = 0;
  logic hold_tx = 0, timed_out = 0;
  logic in_fire = 0, cfg_fire = 0;

  function automatic void pool_init(input logic [3:0] sz);
    int n;
    n = (sz < 1) ? 1 : (sz > NBUF) ? NBUF : sz;
    for (int i = 0; i < NBUF; i++) begin
      m_tag[i] = 0; m_val[i] = 0; m_st[i] = ST_FREE;
      m_inl[i] = (i < n);
      m_nxt[i] = (i < n) ? (i + 1) % n : 0;
      m_prv[i] = (i < n) ? (i + n - 1) % n : 0;
    end
    m_head = 0; m_tail = n - 1; m_cnt = n;
  endfunction

  function automatic void unlink(input int e);
    if (!m_inl[e] || m_cnt == 0) return;
    if (m_cnt == 1) begin
      m_cnt = 0; m_inl[e] = 0; return;
    end
    m_nxt[m_prv[e]] = m_nxt[e];
    m_prv[m_nxt[e]] = m_prv[e];
    if (m_head == e) m_head = m_nxt[e];
    if (m_tail == e) m_tail = m_prv[e];
    m_cnt--; m_inl[e] = 0;
  endfunction

  function automatic void append(input int e);
    if (m_inl[e]) return;
    if (m_cnt == 0) begin
      m_nxt[e] = e; m_prv[e] = e; m_head = e; m_tail = e;
    end else begin
      m_prv[e] = m_tail; m_nxt[e] = m_head;
      m_nxt[m_tail] = e; m_prv[m_head] = e; m_tail = e;
    end
    m_cnt++; m_inl[e] = 1;
  endfunction

  function automatic void push_rsp(input outc_t oc, input int idx, input logic [15:0] b,
                                   input logic l);
    rsp_t r;
    r.oc = oc; r.idx = idx[2:0]; r.blk = b; r.last = l;
    expected_rsps.push_back(r);
  endfunction

  function automatic void predict_request(input req_t q);
    int h, e;
    h = -1;
    for (int i = NBUF - 1; i >= 0; i--) if (m_val[i] && m_tag[i] == q.blk) h = i;
    if (!q.kind) begin
      if (h >= 0) begin
        if (m_st[h] == ST_BUSY) push_rsp(OC_RETRY_BUSY, h, m_tag[h], 1);
        else begin
          unlink(h); m_st[h] = ST_BUSY; push_rsp(OC_HIT, h, m_tag[h], 1);
        end
      end else if (m_cnt == 0) push_rsp(OC_RETRY_EMPTY, 0, q.blk, 1);
      else begin
        e = m_head;
        if (m_st[e] == ST_DELAYED) begin
          push_rsp(OC_WRITEBACK, e, m_tag[e], 0); n_wb++;
        end
        unlink(e);
        m_tag[e] = q.blk; m_val[e] = 1; m_st[e] = ST_BUSY;
        push_rsp(OC_MISS, e, q.blk, 1);
      end
    end else if (h < 0) push_rsp(OC_REL_ERROR, 0, q.blk, 1);
    else if (m_st[h] != ST_BUSY) push_rsp(OC_REL_ERROR, h, m_tag[h], 1);
    else begin
      m_st[h] = q.rel ? ST_DELAYED : ST_FREE;
      append(h); n_rel++;
      push_rsp(OC_RELEASED, h, m_tag[h], 1);
    end
  endfunction

  // handshakes seen at the last rising edge
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_fire) begin
      end else if (gap_left > 0 || hold_tx || pending_reqs.size() == 0) begin
        in_tvalid <= 0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        req_t q;
        q = pending_reqs.pop_front();
        in_tdata <= {q.pid, q.blk};
        in_tuser <= {q.rel, q.kind};
        in_tvalid <= 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0, stall_ctr = 0;
  always @(negedge clk) begin
    stall_ctr <= stall_ctr + 1;
    if (stall_ctr % 200 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= (stall_ctr % 7) < 2;
      default: out_tready <= $urandom_range(0, 9) == 0;
    endcase
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (cfg_valid && cfg_ready) ||
          (out_tvalid && out_tready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (in_tvalid && in_tready) begin
        req_t q;
        q.kind = in_tuser[0]; q.rel = in_tuser[1];
        q.blk = in_tdata[15:0]; q.pid = in_tdata[23:16];
        predict_request(q);
      end
      if (out_tvalid && out_tready) begin
        n_beats <= n_beats + 1;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected beat %h last %b", $time, out_tdata, out_tlast);
          errors <= errors + 1;
        end else begin
          rsp_t x;
          x = expected_rsps.pop_front();
          if (out_tdata[2:0] != x.oc || out_tdata[5:3] != x.idx ||
              out_tdata[21:6] != x.blk || out_tlast != x.last) begin
            $display("%0t: mismatch exp oc=%0d idx=%0d blk=%h last=%b act oc=%0d idx=%0d blk=%h last=%b",
                     $time, x.oc, x.idx, x.blk, x.last, out_tdata[2:0], out_tdata[5:3],
                     out_tdata[21:6], out_tlast);
            errors <= errors + 1;
          end
        end
      end
      if (wdog >= WDOG_LIMIT) timed_out <= 1;
    end
  end

  always @(posedge clk) if (timed_out) begin
    $display("FAILURE");
    $finish;
  end

  function automatic req_t mk(input logic k, input logic [15:0] b, input logic [7:0] p,
                              input logic r);
    req_t q;
    q.kind = k; q.blk = b; q.pid = p; q.rel = r;
    return q;
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_tvalid || expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool(input logic [3:0] v);
    @(negedge clk);
    cfg_data <= v; cfg_valid <= 1;
    @(negedge clk);
    while (!cfg_fire) @(negedge clk);
    cfg_valid <= 0;
    pool_init(v);
  endtask

  // random traffic on a small working set so hits, busy and writebacks occur
  task automatic random_phase(input int n);
    logic [15:0] ws [6];
    int r;
    for (int i = 0; i < 6; i++) ws[i] = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      pending_reqs.push_back(mk(r < 9 ? 1'b0 : r < 18 ? 1'b1 : 1'($urandom_range(0, 1)),
                                r == 19 ? 16'($urandom) : ws[$urandom_range(0, 5)],
                                8'($urandom), 1'($urandom)));
      if (i == n / 2) begin
        wait (pending_reqs.size() == 0);
        hold_tx = 1;
        while (expected_rsps.size() != 0 || in_tvalid) @(posedge clk);
        hold_tx = 0;
      end
    end
  endtask

  initial begin
    pool_init(4'd8);
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1;
    // directed
    pending_reqs.push_back(mk(1, 16'h0000, 8'h00, 0));
    pending_reqs.push_back(mk(0, 16'hFFFF, 8'hFF, 0));
    pending_reqs.push_back(mk(0, 16'hFFFF, 8'h01, 0));
    pending_reqs.push_back(mk(1, 16'hFFFF, 8'h00, 1));
    pending_reqs.push_back(mk(1, 16'hFFFF, 8'h00, 0));
    pending_reqs.push_back(mk(0, 16'hFFFF, 8'h22, 0));
    pending_reqs.push_back(mk(0, 16'h0000, 8'h00, 0));
    pending_reqs.push_back(mk(1, 16'h1234, 8'hAA, 1));
    wait_idle();
    write_pool(4'd1);
    pending_reqs.push_back(mk(0, 16'hAAAA, 8'h55, 0));
    pending_reqs.push_back(mk(0, 16'h5555, 8'hAA, 1));
    pending_reqs.push_back(mk(1, 16'hAAAA, 8'h55, 1));
    pending_reqs.push_back(mk(0, 16'h5555, 8'h10, 0));
    pending_reqs.push_back(mk(1, 16'h5555, 8'h10, 1));
    pending_reqs.push_back(mk(0, 16'h5555, 8'h11, 0));
    pending_reqs.push_back(mk(1, 16'h5555, 8'h10, 1));
    pending_reqs.push_back(mk(0, 16'h0001, 8'h12, 0));
    wait_idle();
    write_pool(4'd0);
    random_phase(250);
    wait_idle();
    write_pool(4'd15);
    random_phase(400);
    wait_idle();
    write_pool(4'd3);
    random_phase(400);
    wait_idle();
    write_pool(4'd8);
    random_phase(800);
    wait_idle();
    $display("Covered %0d result beats, %0d releases, %0d writebacks over pool sizes 0,1,3,8,15.",
             n_beats, n_rel, n_wb);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/bc_pkg.sv
src/bc_out_reg.sv
src/buffer_cache_getblk_brelse_core.sv
tb/sv/tb.sv
